[hdl/jsu_pkg.sv]
// Shared types, codes and helpers for the JSON string unescaper.
`default_nettype none
package jsu_pkg;

    localparam int unsigned QUEUE_DEPTH = 4;

    typedef logic [2:0] status_t;

    localparam status_t ST_BYTE   = 3'd0;
    localparam status_t ST_CLOSED = 3'd1;
    localparam status_t ST_UEND   = 3'd2;
    localparam status_t ST_QUOTE  = 3'd3;
    localparam status_t ST_BADESC = 3'd4;
    localparam status_t ST_BADUNI = 3'd5;
    localparam status_t ST_BADHEX = 3'd6;
    localparam status_t ST_UNTERM = 3'd7;

    localparam logic [7:0]  UTF8_LEAD2 = 8'hC0;
    localparam logic [7:0]  UTF8_LEAD3 = 8'hE0;
    localparam logic [7:0]  UTF8_CONT  = 8'h80;
    localparam logic [7:0]  UTF8_MASK  = 8'h3F;
    localparam logic [15:0] CP_2BYTE   = 16'h0080;
    localparam logic [15:0] CP_3BYTE   = 16'h0800;

    // One queue entry: all result beats caused by one input beat.
    typedef struct packed {
        logic [1:0]      count;   // 1 to 3 beats
        status_t         status;  // shared by every beat of the entry
        logic [7:0]      byte2;
        logic [7:0]      byte1;
        logic [7:0]      byte0;
    } job_t;

    // Queue handshake toward each side.
    typedef struct packed {
        logic valid;
        job_t job;
    } job_beat_t;

    typedef struct packed {
        logic is_hex;
        logic [3:0] value;
    } hex_t;

    function automatic hex_t hex_value(input logic [7:0] c);
        hex_t h;
        h.is_hex = 1'b1;
        h.value  = 4'd0;
        if (c >= 8'h30 && c <= 8'h39)
            h.value = 4'(c - 8'h30);
        else if (c >= 8'h61 && c <= 8'h66)
            h.value = 4'(c - 8'h57);
        else if (c >= 8'h41 && c <= 8'h46)
            h.value = 4'(c - 8'h37);
        else
            h.is_hex = 1'b0;
        return h;
    endfunction

endpackage
`default_nettype wire

[hdl/jsu_text_if.sv]
// Input channel: raw text beats with an end-of-text marker.
`default_nettype none
interface jsu_text_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       end_of_text;

    modport source (output valid, output text_byte, output end_of_text, input ready);
    modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface
`default_nettype wire

[hdl/jsu_result_if.sv]
// Output channel: decoded bytes and status beats.
`default_nettype none
interface jsu_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [2:0] status;
    logic       last;

    modport source (output valid, output out_byte, output status, output last, input ready);
    modport sink   (input valid, input out_byte, input status, input last, output ready);
endinterface
`default_nettype wire

[hdl/jsu_front.sv]
// Front end: string/escape/unicode decoder producing at most one queue entry per input beat.
`default_nettype none
module jsu_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    jsu_text_if.sink                text,
    input  wire logic               push_ready,
    output jsu_pkg::job_beat_t      push
);

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_STR,
        MODE_ESC,
        MODE_HEX
    } mode_t;

    mode_t       mode_reg, mode_next;
    logic [1:0]  digits_reg, digits_next;
    logic [15:0] cp_reg, cp_next;
    logic        bad_reg, bad_next;

    jsu_pkg::job_t job;
    jsu_pkg::hex_t hex;
    logic [15:0]   cp_shift;
    logic          bad_now;
    logic [7:0]    c;
    logic          accept;

    assign c          = text.text_byte;
    assign text.ready = push_ready;
    assign accept     = text.valid && push_ready;

    always_comb
    begin
        hex       = jsu_pkg::hex_value(c);
        cp_shift  = {cp_reg[11:0], hex.value};
        bad_now   = bad_reg || !hex.is_hex;

        mode_next   = mode_reg;
        digits_next = digits_reg;
        cp_next     = cp_reg;
        bad_next    = bad_reg;

        job.count  = 2'd0;
        job.status = jsu_pkg::ST_BYTE;
        job.byte0  = 8'h00;
        job.byte1  = 8'h00;
        job.byte2  = 8'h00;

        case (mode_reg)
            MODE_IDLE:
            begin
                if (text.end_of_text)
                begin
                    job.count  = 2'd1;
                    job.status = jsu_pkg::ST_UEND;
                end
                else if (c inside {8'h20, [8'h09:8'h0D]})
                begin
                    // white space before the string is dropped
                end
                else if (c == 8'h22)
                    mode_next = MODE_STR;
                else
                begin
                    job.count  = 2'd1;
                    job.status = jsu_pkg::ST_QUOTE;
                end
            end
            MODE_STR:
            begin
                if (text.end_of_text)
                begin
                    job.count  = 2'd1;
                    job.status = jsu_pkg::ST_UNTERM;
                    mode_next  = MODE_IDLE;
                end
                else if (c == 8'h22)
                begin
                    job.count  = 2'd1;
                    job.status = jsu_pkg::ST_CLOSED;
                    mode_next  = MODE_IDLE;
                end
                else if (c == 8'h5C)
                    mode_next = MODE_ESC;
                else
                begin
                    job.count = 2'd1;
                    job.byte0 = c;
                end
            end
            MODE_ESC:
            begin
                job.count = 2'd1;
                mode_next = MODE_STR;
                if (text.end_of_text)
                begin
                    job.status = jsu_pkg::ST_BADESC;
                    mode_next  = MODE_IDLE;
                end
                else
                begin
                    case (c)
                        8'h22, 8'h5C, 8'h2F: job.byte0 = c;
                        8'h62:               job.byte0 = 8'h08;
                        8'h66:               job.byte0 = 8'h0C;
                        8'h6E:               job.byte0 = 8'h0A;
                        8'h72:               job.byte0 = 8'h0D;
                        8'h74:               job.byte0 = 8'h09;
                        8'h75:
                        begin
                            job.count   = 2'd0;
                            mode_next   = MODE_HEX;
                            digits_next = 2'd0;
                            cp_next     = 16'h0000;
                            bad_next    = 1'b0;
                        end
                        default:
                        begin
                            job.status = jsu_pkg::ST_BADESC;
                            mode_next  = MODE_IDLE;
                        end
                    endcase
                end
            end
            default:
            begin
                if (text.end_of_text)
                begin
                    job.count  = 2'd1;
                    job.status = jsu_pkg::ST_BADUNI;
                    mode_next  = MODE_IDLE;
                end
                else if (digits_reg != 2'd3)
                begin
                    digits_next = digits_reg + 2'd1;
                    cp_next     = cp_shift;
                    bad_next    = bad_now;
                end
                else if (bad_now)
                begin
                    job.count  = 2'd1;
                    job.status = jsu_pkg::ST_BADHEX;
                    mode_next  = MODE_IDLE;
                end
                else
                begin
                    mode_next = MODE_STR;
                    if (cp_shift < jsu_pkg::CP_2BYTE)
                    begin
                        job.count = 2'd1;
                        job.byte0 = cp_shift[7:0];
                    end
                    else if (cp_shift < jsu_pkg::CP_3BYTE)
                    begin
                        job.count = 2'd2;
                        job.byte0 = jsu_pkg::UTF8_LEAD2 | {3'b000, cp_shift[10:6]};
                        job.byte1 = jsu_pkg::UTF8_CONT
                                  | (jsu_pkg::UTF8_MASK & {2'b00, cp_shift[5:0]});
                    end
                    else
                    begin
                        job.count = 2'd3;
                        job.byte0 = jsu_pkg::UTF8_LEAD3 | {4'b0000, cp_shift[15:12]};
                        job.byte1 = jsu_pkg::UTF8_CONT | {2'b00, cp_shift[11:6]};
                        job.byte2 = jsu_pkg::UTF8_CONT
                                  | (jsu_pkg::UTF8_MASK & {2'b00, cp_shift[5:0]});
                    end
                end
                if (mode_next != MODE_HEX)
                begin
                    digits_next = 2'd0;
                    cp_next     = 16'h0000;
                    bad_next    = 1'b0;
                end
            end
        endcase
        if (mode_next == MODE_IDLE)
        begin
            digits_next = 2'd0;
            cp_next     = 16'h0000;
            bad_next    = 1'b0;
        end
    end

    assign push.valid = accept && (job.count != 2'd0);
    assign push.job   = job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            digits_reg <= 2'd0;
            cp_reg     <= 16'h0000;
            bad_reg    <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg   <= mode_next;
            digits_reg <= digits_next;
            cp_reg     <= cp_next;
            bad_reg    <= bad_next;
        end
    end

endmodule
`default_nettype wire

[hdl/jsu_queue.sv]
// Small FIFO of decoded entries between the front and back ends.
`default_nettype none
module jsu_queue #(
    parameter int unsigned Depth = jsu_pkg::QUEUE_DEPTH
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire jsu_pkg::job_beat_t push,
    output logic                    push_ready,
    output jsu_pkg::job_beat_t      pop,
    input  wire logic               pop_ready
);

    localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int unsigned CntW = $clog2(Depth + 1);

    jsu_pkg::job_t mem [Depth];

    logic [PtrW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CntW-1:0] count_reg;
    logic            do_push, do_pop;

    assign push_ready = (count_reg != CntW'(Depth));
    assign do_push    = push.valid && push_ready;
    assign pop.valid  = (count_reg != '0);
    assign do_pop     = pop.valid && pop_ready;
    assign pop.job    = mem[rd_ptr_reg];

    function automatic logic [PtrW-1:0] bump(input logic [PtrW-1:0] p);
        return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
    endfunction

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push.job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= bump(wr_ptr_reg);
            if (do_pop)
                rd_ptr_reg <= bump(rd_ptr_reg);
            if (do_push && !do_pop)
                count_reg <= count_reg + CntW'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - CntW'(1);
        end
    end

endmodule
`default_nettype wire

[hdl/jsu_back.sv]
// Back end: splits each queue entry into result beats and marks the last one.
`default_nettype none
module jsu_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire jsu_pkg::job_beat_t pop,
    output logic                    pop_ready,
    jsu_result_if.source            result
);

    jsu_pkg::job_t cur_reg;
    logic          cur_valid_reg;
    logic [1:0]    idx_reg;
    logic          is_last;
    logic          beat_done;

    assign is_last   = (idx_reg == cur_reg.count - 2'd1);
    assign beat_done = cur_valid_reg && result.ready;
    // refill when empty or as the final beat of the current entry leaves
    assign pop_ready = !cur_valid_reg || (beat_done && is_last);

    assign result.valid  = cur_valid_reg;
    assign result.status = cur_reg.status;
    assign result.last   = is_last;

    always_comb
    begin
        case (idx_reg)
            2'd0:    result.out_byte = cur_reg.byte0;
            2'd1:    result.out_byte = cur_reg.byte1;
            default: result.out_byte = cur_reg.byte2;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (pop_ready && pop.valid)
            cur_reg <= pop.job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
        end
        else if (pop_ready)
        begin
            cur_valid_reg <= pop.valid;
            idx_reg       <= 2'd0;
        end
        else if (beat_done)
            idx_reg <= idx_reg + 2'd1;
    end

endmodule
`default_nettype wire

[hdl/json_string_unescape.sv]
// JSON string unescaper: text beats in, decoded UTF-8 bytes and status beats out.
//
// Channels: "text" takes one raw byte per beat (or an end-of-text marker);
// "result" gives decoded bytes with status 0, or a single status beat for a
// closed string or an error. "last" marks the final result beat caused by
// one text beat; text beats that cause nothing (white space before a string,
// the opening quote, a backslash, hex digits before the fourth) give none.
// A text beat is taken every cycle while the entry queue has room. The
// decoder in the front end finishes each beat in the cycle it is taken; the
// first result beat then passes through the entry queue and the output
// register. The output port sends one beat per cycle while the receiver is
// ready, so a \u escape that becomes three UTF-8 bytes occupies it for three
// beats; the entry queue (QueueDepth entries) absorbs these bursts.
// When the receiver stalls, the current result beat holds; the queue fills
// and then text.ready drops until room frees up.
// Reset empties the queue and the output register and puts the decoder in
// idle, waiting for an opening quote.
`default_nettype none
module json_string_unescape #(
    parameter int unsigned QueueDepth = jsu_pkg::QUEUE_DEPTH
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    jsu_text_if.sink     text,
    jsu_result_if.source result
);

    jsu_pkg::job_beat_t push, pop;
    logic               push_ready, pop_ready;

    jsu_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .text       (text),
        .push_ready (push_ready),
        .push       (push)
    );

    jsu_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_ready (push_ready),
        .pop        (pop),
        .pop_ready  (pop_ready)
    );

    jsu_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop       (pop),
        .pop_ready (pop_ready),
        .result    (result)
    );

endmodule
`default_nettype wire

[test/jsu_result_checker.sv]
// Checker for the JSON string unescaper: decodes text beats and checks each result beat.
`timescale 1ns / 100ps
module jsu_result_checker (
    input  logic  clk,
    input  logic  rst_n,
    jsu_text_if   text,
    jsu_result_if result,
    output int    errors,
    output int    pending
);

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    typedef enum logic [1:0] {
        M_IDLE,
        M_STR,
        M_ESC,
        M_HEX
    } mode_t;

    typedef struct packed {
        logic [7:0]       data;
        jsu_pkg::status_t status;
        logic             last;
    } beat_t;

    mode_t       mode;
    logic [1:0]  hex_cnt;
    logic [15:0] cp;
    logic        hex_bad;
    beat_t       decoded_beats[$];

    function automatic beat_t mk(input logic [7:0] d, input jsu_pkg::status_t s);
        beat_t b;
        b.data   = d;
        b.status = s;
        b.last   = 1'b0;
        return b;
    endfunction

    task automatic go_idle();
        mode    = M_IDLE;
        hex_cnt = 2'd0;
        cp      = 16'h0000;
        hex_bad = 1'b0;
    endtask

    // Next decoder state plus the result beats one text beat causes.
    task automatic decode_text_beat(input logic [7:0] c, input logic eot);
        beat_t      res[3];
        int         n;
        logic [3:0] nib;
        logic       is_hex;
        n = 0;
        case (mode)
            M_IDLE:
            begin
                if (eot)
                begin
                    res[0] = mk(8'h00, jsu_pkg::ST_UEND);
                    n = 1;
                end
                else if (c == CH_QUOTE)
                    mode = M_STR;
                else if (c != 8'h20 && (c < 8'h09 || c > 8'h0D))
                begin
                    res[0] = mk(8'h00, jsu_pkg::ST_QUOTE);
                    n = 1;
                end
            end
            M_STR:
            begin
                if (eot)
                begin
                    res[0] = mk(8'h00, jsu_pkg::ST_UNTERM);
                    n = 1;
                    go_idle();
                end
                else if (c == CH_QUOTE)
                begin
                    res[0] = mk(8'h00, jsu_pkg::ST_CLOSED);
                    n = 1;
                    go_idle();
                end
                else if (c == CH_BSLASH)
                    mode = M_ESC;
                else
                begin
                    res[0] = mk(c, jsu_pkg::ST_BYTE);
                    n = 1;
                end
            end
            M_ESC:
            begin
                if (eot)
                begin
                    res[0] = mk(8'h00, jsu_pkg::ST_BADESC);
                    n = 1;
                    go_idle();
                end
                else
                begin
                    mode = M_STR;
                    n = 1;
                    case (c)
                        CH_QUOTE, CH_BSLASH, "/": res[0] = mk(c, jsu_pkg::ST_BYTE);
                        "b": res[0] = mk(8'h08, jsu_pkg::ST_BYTE);
                        "f": res[0] = mk(8'h0C, jsu_pkg::ST_BYTE);
                        "n": res[0] = mk(8'h0A, jsu_pkg::ST_BYTE);
                        "r": res[0] = mk(8'h0D, jsu_pkg::ST_BYTE);
                        "t": res[0] = mk(8'h09, jsu_pkg::ST_BYTE);
                        "u":
                        begin
                            n = 0;
                            mode    = M_HEX;
                            hex_cnt = 2'd0;
                            cp      = 16'h0000;
                            hex_bad = 1'b0;
                        end
                        default:
                        begin
                            res[0] = mk(8'h00, jsu_pkg::ST_BADESC);
                            go_idle();
                        end
                    endcase
                end
            end
            default:
            begin
                if (eot)
                begin
                    // end of text beats a pending bad digit
                    res[0] = mk(8'h00, jsu_pkg::ST_BADUNI);
                    n = 1;
                    go_idle();
                end
                else
                begin
                    is_hex = 1'b1;
                    nib    = 4'd0;
                    if (c >= 8'h30 && c <= 8'h39)
                        nib = 4'(c - 8'h30);
                    else if (c >= 8'h61 && c <= 8'h66)
                        nib = 4'(c - 8'h61 + 8'd10);
                    else if (c >= 8'h41 && c <= 8'h46)
                        nib = 4'(c - 8'h41 + 8'd10);
                    else
                        is_hex = 1'b0;
                    cp = {cp[11:0], nib};
                    if (!is_hex)
                        hex_bad = 1'b1;
                    if (hex_cnt != 2'd3)
                        hex_cnt = hex_cnt + 2'd1;
                    else if (hex_bad)
                    begin
                        res[0] = mk(8'h00, jsu_pkg::ST_BADHEX);
                        n = 1;
                        go_idle();
                    end
                    else
                    begin
                        if (cp < jsu_pkg::CP_2BYTE)
                        begin
                            res[0] = mk(cp[7:0], jsu_pkg::ST_BYTE);
                            n = 1;
                        end
                        else if (cp < jsu_pkg::CP_3BYTE)
                        begin
                            res[0] = mk(jsu_pkg::UTF8_LEAD2 | {3'b000, cp[10:6]},
                                        jsu_pkg::ST_BYTE);
                            res[1] = mk(jsu_pkg::UTF8_CONT | {2'b00, cp[5:0]},
                                        jsu_pkg::ST_BYTE);
                            n = 2;
                        end
                        else
                        begin
                            res[0] = mk(jsu_pkg::UTF8_LEAD3 | {4'b0000, cp[15:12]},
                                        jsu_pkg::ST_BYTE);
                            res[1] = mk(jsu_pkg::UTF8_CONT | {2'b00, cp[11:6]},
                                        jsu_pkg::ST_BYTE);
                            res[2] = mk(jsu_pkg::UTF8_CONT | {2'b00, cp[5:0]},
                                        jsu_pkg::ST_BYTE);
                            n = 3;
                        end
                        go_idle();
                        mode = M_STR;
                    end
                end
            end
        endcase
        for (int i = 0; i < n; i++)
        begin
            res[i].last = (i == n - 1);
            decoded_beats = {decoded_beats, res[i]};
        end
    endtask

    task automatic compare_field(input string name, input logic [7:0] want,
                                 input logic [7:0] got);
        if (got !== want)
        begin
            errors++;
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
        end
    endtask

    task automatic check_result_beat(input logic [7:0] d, input jsu_pkg::status_t s,
                                     input logic l);
        beat_t want;
        if (decoded_beats.size() == 0)
        begin
            errors++;
            $error("result beat with nothing expected: out_byte %0h status %0d last %0d",
                   d, s, l);
        end
        else
        begin
            want = decoded_beats.pop_front();
            compare_field("out_byte", want.data, d);
            compare_field("status", {5'b0, want.status}, {5'b0, s});
            compare_field("last", {7'b0, want.last}, {7'b0, l});
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            go_idle();
            decoded_beats.delete();
            errors  = 0;
            pending = 0;
        end
        else
        begin
            if (text.valid && text.ready)
                decode_text_beat(text.text_byte, text.end_of_text);
            if (result.valid && result.ready)
                check_result_beat(result.out_byte, result.status, result.last);
            pending = decoded_beats.size();
        end
    end

endmodule

[test/tb_top.sv]
// Top of the unescaper testbench: clock, reset, text stimulus, result stalls and verdict.
`timescale 1ns / 100ps
module tb_top;

    localparam logic [7:0] QUOTE       = 8'h22;
    localparam logic [7:0] BSLASH      = 8'h5C;
    localparam int         TEXT_BEATS   = 210;
    localparam int         STALL_LIMIT  = 2000;
    localparam int         DRAIN_CYCLES = 20;

    typedef struct packed {
        logic [7:0] ch;
        logic       eot;
    } text_beat_t;

    logic clk = 1'b0;
    logic rst_n;
    int   fail_count;
    int   beats_pending;
    int   quiet_cycles = 0;
    int   n_text = 0;
    int   n_end = 0;
    int   n_result = 0;
    int   status_count[8];

    text_beat_t text_q[$];

    jsu_text_if   text_ch ();
    jsu_result_if result_ch ();

    json_string_unescape DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .text   (text_ch),
        .result (result_ch)
    );

    jsu_result_checker u_checker (
        .clk     (clk),
        .rst_n   (rst_n),
        .text    (text_ch),
        .result  (result_ch),
        .errors  (fail_count),
        .pending (beats_pending)
    );

    always #5 clk = ~clk;

    task automatic add_byte(input logic [7:0] b);
        text_beat_t t;
        t.ch  = b;
        t.eot = 1'b0;
        text_q = {text_q, t};
    endtask

    // The byte under an end marker is ignored, so it carries noise.
    task automatic add_end();
        text_beat_t t;
        t.ch  = 8'($urandom_range(0, 255));
        t.eot = 1'b1;
        text_q = {text_q, t};
    endtask

    task automatic add_str(input string s);
        for (int i = 0; i < s.len(); i++)
            add_byte(s[i]);
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        if (v < 4'd10)
            return 8'h30 + 8'(v);
        return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + 8'(v) - 8'd10;
    endfunction

    // One string, mostly well formed, sometimes broken or preceded by noise.
    task automatic add_random_text();
        string       esc_letters;
        string       bad_esc;
        string       not_hex;
        int          r;
        int          pos;
        logic [15:0] cp;
        logic [7:0]  ch;
        esc_letters = "\"\\/bfnrt";
        bad_esc     = "aqxzU0 ";
        not_hex     = "gGzZ.- ";
        r = $urandom_range(0, 99);
        if (r < 6)
            add_byte(8'($urandom_range(0, 255)));
        else if (r < 9)
            add_end();
        repeat ($urandom_range(0, 2))
        begin
            r = $urandom_range(0, 5);
            add_byte(r == 5 ? 8'h20 : 8'(8'h09 + r));
        end
        add_byte(QUOTE);
        repeat ($urandom_range(0, 6))
        begin
            r = $urandom_range(0, 9);
            if (r < 4)
            begin
                do
                    ch = 8'($urandom_range(0, 255));
                while (ch == QUOTE || ch == BSLASH);
                add_byte(ch);
            end
            else if (r < 6)
            begin
                add_byte(BSLASH);
                add_byte(esc_letters[$urandom_range(0, 7)]);
            end
            else
            begin
                case ($urandom_range(0, 3))
                    0: cp = 16'($urandom_range(0, 'h7F));
                    1: cp = 16'($urandom_range('h80, 'h7FF));
                    2: cp = 16'($urandom_range('h800, 'hFFFF));
                    default:
                        case ($urandom_range(0, 5))
                            0: cp = 16'h0000;
                            1: cp = 16'h007F;
                            2: cp = 16'h0080;
                            3: cp = 16'h07FF;
                            4: cp = 16'h0800;
                            default: cp = 16'hFFFF;
                        endcase
                endcase
                add_str("\\u");
                add_byte(hex_char(cp[15:12]));
                add_byte(hex_char(cp[11:8]));
                add_byte(hex_char(cp[7:4]));
                add_byte(hex_char(cp[3:0]));
            end
        end
        r = $urandom_range(0, 99);
        if (r < 78)
            add_byte(QUOTE);
        else if (r < 83)
            add_end();
        else if (r < 87)
        begin
            add_byte(BSLASH);
            add_byte(bad_esc[$urandom_range(0, bad_esc.len() - 1)]);
        end
        else if (r < 90)
        begin
            add_byte(BSLASH);
            add_end();
        end
        else if (r < 95)
        begin
            add_str("\\u");
            pos = $urandom_range(0, 3);
            for (int k = 0; k < 4; k++)
                add_byte(k == pos ? not_hex[$urandom_range(0, not_hex.len() - 1)]
                                  : hex_char(4'($urandom_range(0, 15))));
        end
        else
        begin
            add_str("\\u");
            repeat ($urandom_range(0, 3))
                add_byte($urandom_range(0, 3) == 0 ? not_hex[$urandom_range(0, 6)]
                                                   : hex_char(4'($urandom_range(0, 15))));
            add_end();
        end
    endtask

    // Sender: bursts of beats with random gaps.
    initial
    begin
        int         burst;
        int         gap;
        text_beat_t item;
        rst_n               = 1'b0;
        text_ch.valid       = 1'b0;
        text_ch.text_byte   = 8'h00;
        text_ch.end_of_text = 1'b0;

        add_end();                 // end of text while idle
        add_byte(8'hFF);           // stray byte while idle
        add_byte(8'h0B);           // white space is skipped
        add_byte(QUOTE);
        add_byte(8'h00);
        add_str("\\u0000");
        add_str("\\q");            // unknown escape letter
        add_str("\"\\ug");         // bad digit, then end inside the hex digits
        add_end();
        add_str("\"\\uzFFF");      // bad digit reported at the fourth
        add_str("\"\\");           // end right after backslash
        add_end();
        add_byte(QUOTE);           // end inside string
        add_end();
        add_str("\"\"");
        while (text_q.size() < TEXT_BEATS)
            add_random_text();

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        while (text_q.size() > 0)
        begin
            burst = $urandom_range(1, 16);
            for (int i = 0; i < burst && text_q.size() > 0; i++)
            begin
                item = text_q.pop_front();
                text_ch.valid       <= 1'b1;
                text_ch.text_byte   <= item.ch;
                text_ch.end_of_text <= item.eot;
                do
                    @(posedge clk);
                while (!text_ch.ready);
                @(negedge clk);
            end
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                text_ch.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        text_ch.valid <= 1'b0;

        wait (beats_pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Run covered %0d text beats (%0d end markers) and %0d result beats.",
                 n_text, n_end, n_result);
        $display("Result beats by status: byte %0d, closed %0d, end %0d, quote %0d,",
                 status_count[0], status_count[1], status_count[2], status_count[3]);
        $display("  esc/uni/hex/unterm %0d %0d %0d %0d",
                 status_count[4], status_count[5], status_count[6], status_count[7]);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Receiver: stretches of full rate, random stalls, heavy stalls and hard stops.
    initial
    begin
        int style;
        int span;
        result_ch.ready = 1'b0;
        forever
        begin
            style = $urandom_range(0, 3);
            span  = (style == 3) ? $urandom_range(1, 12) : $urandom_range(1, 40);
            repeat (span)
            begin
                @(negedge clk);
                case (style)
                    0: result_ch.ready <= 1'b1;
                    1: result_ch.ready <= 1'($urandom_range(0, 1));
                    2: result_ch.ready <= ($urandom_range(0, 3) == 0);
                    default: result_ch.ready <= 1'b0;
                endcase
            end
        end
    end

    // Beat counts for the summary, and a watchdog on cycles with no beat moving.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (text_ch.valid && text_ch.ready)
            begin
                n_text++;
                if (text_ch.end_of_text)
                    n_end++;
            end
            if (result_ch.valid && result_ch.ready)
            begin
                n_result++;
                status_count[result_ch.status]++;
            end
            if ((text_ch.valid && text_ch.ready) || (result_ch.valid && result_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

endmodule
